/* design/rtio_pkg.sv */
// Shared types, codes and constants for the RIOT timer / RAM / I/O block.
// No dependencies; rtio_timer and riot_timer_ram_io import this package.
package rtio_pkg;

   localparam int RTIO_RAM_DEPTH = 128;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      TGT_NONE  = 3'd0,
      TGT_VIDEO = 3'd1,
      TGT_RAM   = 3'd2,
      TGT_IO    = 3'd3,
      TGT_ROM   = 3'd4
   } tgt_type;

   localparam logic [12:0] ADDR_ROM_BASE = 13'h1000;
   localparam logic [12:0] IO_PORTA      = 13'h280;
   localparam logic [12:0] IO_PORTA_M    = 13'h290;
   localparam logic [12:0] IO_TIMER      = 13'h284;
   localparam logic [12:0] IO_TIMER_M    = 13'h294;
   // Timer load group: address bits [12:2] of 0x284-0x287 and its mirror
   localparam logic [10:0] IO_TIMER_GRP   = IO_TIMER[12:2];
   localparam logic [10:0] IO_TIMER_GRP_M = IO_TIMER_M[12:2];
   localparam logic [7:0]  IO_OPEN_BUS   = 8'hFF;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
      logic [7:0]  joystick_pins;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] target;
   } rsp_type;

   typedef struct packed {
      logic       tick;
      logic       load;
      logic       restore;
      logic [1:0] scale;
      logic [7:0] data;
   } timer_ctrl_type;

   function automatic logic [10:0] interval_of(input logic [1:0] scale);
      logic [10:0] iv;
      case (scale)
         2'd0:    iv = 11'd1;
         2'd1:    iv = 11'd8;
         2'd2:    iv = 11'd64;
         default: iv = 11'd1024;
      endcase
      return iv;
   endfunction

endpackage

/* design/rtio_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rtio_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/rtio_timer.sv */
// Interval timer: prescaler, count value and active / set intervals.
// Depends on rtio_pkg (timer_ctrl_type, interval_of).
module rtio_timer
   import rtio_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  timer_ctrl_type ctrl,
   output logic [7:0]     timer_value
);

   logic [15:0] pc_ff, pc_in, pc_inc;
   logic [7:0]  tv_ff, tv_in, tv_dec;
   logic [10:0] act_ff, act_in;
   logic [10:0] set_ff, set_in;

   assign pc_inc      = pc_ff + 16'd1;
   assign tv_dec      = tv_ff - 8'd1;
   assign timer_value = tv_ff;

   always_comb begin
      pc_in  = pc_ff;
      tv_in  = tv_ff;
      act_in = act_ff;
      set_in = set_ff;
      if (ctrl.tick) begin
         if (pc_inc == {5'd0, act_ff}) begin
            pc_in = '0;
            tv_in = tv_dec;
            if (tv_dec == 8'hFF) begin
               act_in = 11'd1;
            end
         end else begin
            pc_in = pc_inc;
         end
      end else if (ctrl.load) begin
         set_in = interval_of(ctrl.scale);
         act_in = interval_of(ctrl.scale);
         tv_in  = ctrl.data - 8'd1;
      end else if (ctrl.restore) begin
         act_in = set_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         tv_ff  <= '0;
         act_ff <= '0;
         set_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         tv_ff  <= tv_in;
         act_ff <= act_in;
         set_ff <= set_in;
      end
   end

endmodule

/* design/riot_timer_ram_io.sv */
// Top level of the RIOT timer / scratch RAM / I/O block with its bus decode.
// Depends on rtio_pkg, rtio_ram and rtio_timer.
//
// Usage:
//   req channel: one beat per cpu cycle: a tick, a bus read or a bus write.
//   rsp channel: exactly one beat per request beat, in order, carrying the
//     read byte and the decoded target code.
//   Path: a request beat is captured in the read stage, where the RAM read
//     data is registered, and then moves on into the output register.
//   Throughput: one beat per clock while req_stall is low; the scratch RAM
//     port and the timer registers are touched once per beat.
//   Reset: synchronous, active high. Clears the timer state, the pipeline
//     valids and the per-entry RAM valid bits, so every RAM byte reads zero
//     until written. No clearing pass; requests are taken right after reset.
//   Stall: the output register holds a beat while rsp_stall is high; one
//     more beat may enter and wait in the read stage. Only when both are
//     full does req_stall rise.
module riot_timer_ram_io
   import rtio_pkg::*;
#(
   parameter int RAM_DEPTH = RTIO_RAM_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int RAM_AW = $clog2(RAM_DEPTH);

   logic                 acc;
   logic [12:0]          a13;
   logic                 is_rd, is_wr;
   tgt_type              tgt;
   logic [RAM_AW-1:0]    idx;
   logic [7:0]           io_rd;
   logic [7:0]           timer_value;
   logic [7:0]           ram_rdata;
   logic                 ram_wr;
   timer_ctrl_type       tctrl;

   logic [RAM_DEPTH-1:0] ram_vld_ff, ram_vld_in;

   // Read stage: waits for the RAM read data
   logic                 s1_vld_ff, s1_vld_in;
   tgt_type              s1_tgt_ff;
   logic [7:0]           s1_data_ff;
   logic                 s1_ram_ff;
   logic                 s1_hit_ff;
   logic                 s1_adv;
   rsp_type              s1_rsp;

   // Output register
   logic                 out_vld_ff, out_vld_in;
   rsp_type              out_data_ff;

   assign s1_adv    = s1_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign acc       = req_valid && !req_stall;

   assign a13   = req_data.bus_address[12:0];
   assign is_rd = (req_data.cmd == CMD_READ);
   assign is_wr = (req_data.cmd == CMD_WRITE);
   assign idx   = a13[RAM_AW-1:0];

   // Decode the target: ROM area first, then video chip, RAM, I/O
   always_comb begin
      if (!(is_rd || is_wr)) begin
         tgt = TGT_NONE;
      end else if (a13 >= ADDR_ROM_BASE) begin
         tgt = TGT_ROM;
      end else if (!a13[7]) begin
         tgt = TGT_VIDEO;
      end else if (!a13[9]) begin
         tgt = TGT_RAM;
      end else begin
         tgt = TGT_IO;
      end
   end

   // I/O read mux; full 13-bit compare, so stray mirrors read open bus
   always_comb begin
      case (a13)
         IO_PORTA, IO_PORTA_M: io_rd = req_data.joystick_pins;
         IO_TIMER, IO_TIMER_M: io_rd = timer_value;
         default:              io_rd = IO_OPEN_BUS;
      endcase
   end

   // Timer control: only one action per beat
   always_comb begin
      tctrl         = '0;
      tctrl.tick    = acc && (req_data.cmd == CMD_TICK);
      tctrl.load    = acc && is_wr && (tgt == TGT_IO) &&
                      (a13[12:2] inside {IO_TIMER_GRP, IO_TIMER_GRP_M});
      tctrl.restore = acc && is_rd && (tgt == TGT_IO) &&
                      (a13 inside {IO_TIMER, IO_TIMER_M});
      tctrl.scale   = a13[1:0];
      tctrl.data    = req_data.write_data;
   end

   rtio_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (tctrl),
      .timer_value (timer_value)
   );

   // Scratch RAM; a write lands at the accept edge, so a read on the next
   // beat already sees it
   assign ram_wr = acc && is_wr && (tgt == TGT_RAM);

   rtio_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (idx),
      .wr_data (req_data.write_data),
      .rd_en   (acc),
      .rd_addr (idx),
      .rd_data (ram_rdata)
   );

   // Mark written entries; unwritten ones read as zero
   always_comb begin
      ram_vld_in = ram_vld_ff;
      if (ram_wr) begin
         ram_vld_in[idx] = 1'b1;
      end
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (acc) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_vld_ff <= '0;
         s1_vld_ff  <= 1'b0;
      end else begin
         ram_vld_ff <= ram_vld_in;
         s1_vld_ff  <= s1_vld_in;
      end
   end

   // Capture the decoded beat; read stage payload holds while stalled
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_tgt_ff  <= tgt;
         s1_data_ff <= (is_rd && (tgt == TGT_IO)) ? io_rd : 8'd0;
         s1_ram_ff  <= is_rd && (tgt == TGT_RAM);
         s1_hit_ff  <= ram_vld_ff[idx];
      end
   end

   always_comb begin
      s1_rsp.target = s1_tgt_ff;
      if (s1_ram_ff) begin
         s1_rsp.read_data = s1_hit_ff ? ram_rdata : 8'd0;
      end else begin
         s1_rsp.read_data = s1_data_ff;
      end
   end

   // Advance into the output register, or drop the valid once taken
   always_comb begin
      out_vld_in = out_vld_ff;
      if (s1_adv) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_data_ff <= s1_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   // A RAM write marks its entry valid for later reads
   a_ram_mark: assert property (@(posedge clock) disable iff (reset)
      ram_wr |=> ram_vld_ff[$past(idx)])
      else $error("RAM valid bit not set after write");

   // Ticks and unused commands never return data
   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.target == TGT_NONE) |-> rsp_data.read_data == 8'd0)
      else $error("tick beat carries read data");

   // Nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_vld_ff)
      else $error("pipeline valid after reset");

   // Input is held off only when both stages are full and the output stalls
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff && out_vld_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");
`endif

endmodule

/* sim/riot_timer_ram_io_checker.sv */
// Scoreboard for riot_timer_ram_io: watches the req and rsp channels, keeps a bus and timer model,
// and compares every response beat with its predicted value.
// Depends on rtio_pkg for the payload types, command and target codes and address constants.
module riot_timer_ram_io_checker
   import rtio_pkg::*;
#(
   parameter int RAM_DEPTH = RTIO_RAM_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding
);

   // prescale interval selected by the low two address bits of a timer load
   localparam logic [3:0][10:0] PRESCALE_STEPS = {11'd1024, 11'd64, 11'd8, 11'd1};

   logic [7:0]  ram_img [RAM_DEPTH];
   logic [15:0] prescale_cnt;
   logic [7:0]  timer_val;
   logic [10:0] live_interval;
   logic [10:0] loaded_interval;

   rsp_type awaited_rsp [$];
   rsp_type want;
   int      errs = 0;

   function automatic rsp_type bus_access_model(input req_type r);
      logic [12:0] a;
      rsp_type     e;
      a = r.bus_address[12:0];
      e = '0;
      case (r.cmd)
         CMD_TICK: begin
            prescale_cnt = prescale_cnt + 16'd1;
            if (prescale_cnt == {5'd0, live_interval}) begin
               prescale_cnt = '0;
               timer_val = timer_val - 8'd1;
               if (timer_val == 8'hFF) live_interval = PRESCALE_STEPS[0];
            end
         end
         CMD_READ, CMD_WRITE: begin
            if (a >= ADDR_ROM_BASE) begin
               e.target = TGT_ROM;
            end else if (!a[7]) begin
               e.target = TGT_VIDEO;
            end else if (!a[9]) begin
               e.target = TGT_RAM;
               if (r.cmd == CMD_WRITE) ram_img[a[6:0]] = r.write_data;
               else e.read_data = ram_img[a[6:0]];
            end else begin
               e.target = TGT_IO;
               if (r.cmd == CMD_WRITE) begin
                  // only the timer load group and its mirror take writes
                  if (a[12:2] inside {IO_TIMER_GRP, IO_TIMER_GRP_M}) begin
                     loaded_interval = PRESCALE_STEPS[a[1:0]];
                     live_interval = loaded_interval;
                     timer_val = r.write_data - 8'd1;
                  end
               end else if (a inside {IO_PORTA, IO_PORTA_M}) begin
                  e.read_data = r.joystick_pins;
               end else if (a inside {IO_TIMER, IO_TIMER_M}) begin
                  live_interval = loaded_interval;
                  e.read_data = timer_val;
               end else begin
                  e.read_data = IO_OPEN_BUS;
               end
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   task automatic log_mismatch(input string what, input logic [7:0] want_v, got_v);
      if (errs < 10) $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
      errs++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RAM_DEPTH; i++) ram_img[i] = '0;
         prescale_cnt = '0;
         timer_val = '0;
         live_interval = '0;
         loaded_interval = '0;
         awaited_rsp.delete();
         outstanding <= 0;
         fail_count <= 0;
      end else begin
         // retire the response beat before queuing this edge's request beat
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               if (errs < 10) $display("%0t: rsp beat with nothing awaited: read_data %h target %h",
                                       $time, rsp_data.read_data, rsp_data.target);
               errs++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  log_mismatch("read_data", want.read_data, rsp_data.read_data);
               if (rsp_data.target !== want.target)
                  log_mismatch("target", 8'(want.target), 8'(rsp_data.target));
            end
         end
         if (req_valid && !req_stall) awaited_rsp.push_back(bus_access_model(req_data));
         outstanding <= awaited_rsp.size();
         fail_count <= errs;
      end
   end

endmodule

/* sim/riot_timer_ram_io_tb.sv */
// Testbench top for riot_timer_ram_io: clock, reset, request stimulus, response stall and verdict.
// Depends on rtio_pkg, the riot_timer_ram_io design and riot_timer_ram_io_checker.
module riot_timer_ram_io_tb;
   import rtio_pkg::*;

   // the command code the block treats as a no-op
   localparam logic [1:0]  CMD_SPARE   = 2'd3;
   // port B data and its mirror; the block returns open bus for both
   localparam logic [12:0] IO_PORTB    = 13'h282;
   localparam logic [12:0] IO_PORTB_M  = 13'h292;
   localparam int          PHASE_BEATS = 450;
   localparam int          CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int idle_pct  = 0;
   int stall_pct = 0;
   int cycles    = 0;

   riot_timer_ram_io u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   riot_timer_ram_io_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver side: stall at the rate the current phase asks for, never during reset.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Hard stop: a hung handshake ends the run here.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   function automatic req_type bus_beat(input logic [1:0] cmd, input logic [15:0] addr,
                                        input logic [7:0] data);
      req_type r;
      r.cmd = cmd;
      r.bus_address = addr;
      r.write_data = data;
      r.joystick_pins = 8'($urandom_range(255));
      return r;
   endfunction

   // Draw one random beat, steering most addresses into the decoded windows.
   // Bits 15:13 stay random everywhere, since the block drops them.
   function automatic req_type random_beat();
      req_type r;
      int      pick;
      r.write_data = 8'($urandom_range(255));
      r.joystick_pins = 8'($urandom_range(255));
      r.bus_address = 16'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 5) r.cmd = CMD_SPARE;
      else if (pick < 40) r.cmd = CMD_TICK;
      else if (pick < 70) r.cmd = CMD_READ;
      else r.cmd = CMD_WRITE;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // scratch RAM: A12=0, A9=0, A7=1
         r.bus_address[12] = 1'b0;
         r.bus_address[9] = 1'b0;
         r.bus_address[7] = 1'b1;
      end else if (pick < 55) begin
         // timer registers and mirror; keep load values small so underflow shows up
         r.bus_address[12:0] = ($urandom_range(1) ? IO_TIMER_M : IO_TIMER) | 13'($urandom_range(3));
         if ($urandom_range(3) != 0) r.write_data = 8'($urandom_range(4));
      end else if (pick < 65) begin
         case ($urandom_range(3))
            0:       r.bus_address[12:0] = IO_PORTA;
            1:       r.bus_address[12:0] = IO_PORTA_M;
            2:       r.bus_address[12:0] = IO_PORTB;
            default: r.bus_address[12:0] = IO_PORTB_M;
         endcase
      end else if (pick < 75) begin
         // any other I/O address, mostly open bus
         r.bus_address[12] = 1'b0;
         r.bus_address[9] = 1'b1;
         r.bus_address[7] = 1'b1;
      end else if (pick < 85) begin
         r.bus_address[12] = 1'b0;
         r.bus_address[7] = 1'b0;
      end else if (pick < 92) begin
         r.bus_address[12] = 1'b1;
      end
      return r;
   endfunction

   // Offer one beat, idling first at the phase rate; return once the block takes it.
   task automatic send(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold until every awaited response beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats, no idling on either side.
      send(bus_beat(CMD_READ,  16'h0080, 8'h00));     // RAM reads zero after reset
      send(bus_beat(CMD_READ,  16'(IO_TIMER), 8'h00)); // timer read before any load
      send(bus_beat(CMD_TICK,  16'h0000, 8'h00));
      send(bus_beat(CMD_WRITE, 16'h0080, 8'hFF));
      send(bus_beat(CMD_WRITE, 16'hE0FF, 8'h00));     // upper address bits dropped
      send(bus_beat(CMD_WRITE, 16'h01FF, 8'h5A));     // same RAM byte through A8
      send(bus_beat(CMD_READ,  16'h0080, 8'h00));
      send(bus_beat(CMD_READ,  16'h00FF, 8'h00));
      send(bus_beat(CMD_READ,  16'(IO_PORTA), 8'h00));
      send(bus_beat(CMD_READ,  16'(IO_PORTA_M), 8'h00));
      send(bus_beat(CMD_READ,  16'(IO_PORTB), 8'h00));
      send(bus_beat(CMD_READ,  16'(IO_PORTB_M), 8'h00));
      send(bus_beat(CMD_WRITE, 16'(IO_PORTA), 8'h12)); // ignored I/O write
      send(bus_beat(CMD_WRITE, 16'h02A4, 8'h05));     // near-mirror of the timer: ignored
      send(bus_beat(CMD_READ,  16'h02A4, 8'h00));     // and reads open bus
      send(bus_beat(CMD_WRITE, 16'(IO_TIMER), 8'h00)); // load of zero wraps to 0xFF
      send(bus_beat(CMD_TICK,  16'hFFFF, 8'hFF));
      send(bus_beat(CMD_READ,  16'(IO_TIMER_M), 8'h00));
      send(bus_beat(CMD_WRITE, 16'(IO_TIMER_M | 13'h3), 8'h02)); // 1024 interval, mirror
      send(bus_beat(CMD_WRITE, 16'(IO_TIMER), 8'h01)); // value 0 at interval 1
      send(bus_beat(CMD_TICK,  16'h0000, 8'h00));     // prescaler already past the interval
      send(bus_beat(CMD_READ,  16'(IO_TIMER), 8'h00)); // read restores the set interval
      send(bus_beat(CMD_READ,  16'h0000, 8'h00));
      send(bus_beat(CMD_READ,  16'h1000, 8'h00));
      send(bus_beat(CMD_WRITE, 16'hFFFF, 8'hFF));     // ROM area after masking
      send(bus_beat(CMD_SPARE, 16'hFFFF, 8'hFF));
      drain();

      // Random phases: free flow, idle sender, stalling receiver, then both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 46; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 11; stall_pct = 11; end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) send(random_beat());
         // hold off the sender until the pipeline is empty
         drain();
      end

      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
design/rtio_pkg.sv
design/rtio_ram.sv
design/rtio_timer.sv
design/riot_timer_ram_io.sv
sim/riot_timer_ram_io_checker.sv
sim/riot_timer_ram_io_tb.sv
